[rtl/core/vml_pkg.sv]
package vml_pkg;

   typedef struct packed {
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [31:0] right_shift;
      logic signed [15:0] upvec_x;
      logic signed [15:0] upvec_y;
      logic signed [15:0] upvec_z;
      logic signed [31:0] upvec_shift;
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [31:0] fwd_shift;
   } rsp_type;

   localparam logic [1:0] CSR_UP_X = 2'd0;
   localparam logic [1:0] CSR_UP_Y = 2'd1;
   localparam logic [1:0] CSR_UP_Z = 2'd2;

   // shift right by sh rounding half away from zero, saturate to 16 bits
   function automatic logic signed [15:0] rnd_sat16(input logic signed [33:0] v,
                                                    input logic [3:0] sh);
      logic [33:0] mag;
      logic [33:0] m;
      begin
         mag = v[33] ? (34'd0 - $unsigned(v)) : $unsigned(v);
         m = (mag + (34'd1 << (sh - 4'd1))) >> sh;
         if (v[33]) begin
            rnd_sat16 = (m > 34'd32768) ? 16'sh8000 : 16'((34'd0 - m));
         end else begin
            rnd_sat16 = (m > 34'd32767) ? 16'sh7fff : 16'(m);
         end
      end
   endfunction

   // same for the translations, saturate to 32 bits
   function automatic logic signed [31:0] rnd_sat32(input logic signed [50:0] v,
                                                    input logic [3:0] sh);
      logic [50:0] mag;
      logic [50:0] m;
      begin
         mag = v[50] ? (51'd0 - $unsigned(v)) : $unsigned(v);
         m = (mag + (51'd1 << (sh - 4'd1))) >> sh;
         if (v[50]) begin
            rnd_sat32 = (m > 51'h80000000) ? 32'sh80000000 : 32'((51'd0 - m));
         end else begin
            rnd_sat32 = (m > 51'h7fffffff) ? 32'sh7fffffff : 32'(m);
         end
      end
   endfunction

endpackage

[rtl/core/vml_norm.sv]
module vml_norm #(
   parameter int FRAC = 14,
   parameter int SW   = 96
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [2:0][33:0]  in_c,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   output logic signed [2:0][15:0]  out_v,
   output logic [SW-1:0]            out_side
);

   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 17;

   typedef struct packed {
      logic             vld;
      logic [2:0]       neg;
      logic [2:0][33:0] mag;
      logic [33:0]      mx;
      logic [SW-1:0]    side;
   } sa_type;

   typedef struct packed {
      logic             vld;
      logic [2:0]       neg;
      logic [2:0][15:0] mag;
      logic [SW-1:0]    side;
   } sb_type;

   typedef struct packed {
      logic             vld;
      logic [2:0]       neg;
      logic [2:0][15:0] mag;
      logic [2:0][31:0] sqr;
      logic [SW-1:0]    side;
   } sc_type;

   typedef struct packed {
      logic             vld;
      logic [2:0]       neg;
      logic             zero;
      logic [2:0][15:0] mag;
      logic [63:0]      x;
      logic [34:0]      rem;
      logic [31:0]      root;
      logic [SW-1:0]    side;
   } sq_type;

   typedef struct packed {
      logic             vld;
      logic [2:0]       neg;
      logic             zero;
      logic [2:0]       ovf;
      logic [2:0][34:0] r;
      logic [2:0][16:0] dd;
      logic [2:0][16:0] q;
      logic [32:0]      d;
      logic [SW-1:0]    side;
   } dv_type;

   typedef struct packed {
      logic                    vld;
      logic signed [2:0][15:0] v;
      logic [SW-1:0]           side;
   } so_type;

   sa_type sa_ff, sa_in;
   sb_type sb_ff, sb_in;
   sc_type sc_ff, sc_in;
   sq_type sq_ff [0:SQ_STEPS];
   sq_type sq_in [0:SQ_STEPS];
   dv_type dv_ff [0:DIV_STEPS];
   dv_type dv_in [0:DIV_STEPS];
   so_type so_ff, so_in;

   // magnitudes, signs, largest magnitude
   always_comb begin
      sa_in.vld  = in_valid;
      sa_in.side = in_side;
      for (int i = 0; i < 3; i++) begin
         sa_in.neg[i] = in_c[i][33];
         sa_in.mag[i] = in_c[i][33] ? (34'd0 - $unsigned(in_c[i])) : $unsigned(in_c[i]);
      end
      sa_in.mx = sa_in.mag[0];
      if (sa_in.mag[1] > sa_in.mx) sa_in.mx = sa_in.mag[1];
      if (sa_in.mag[2] > sa_in.mx) sa_in.mx = sa_in.mag[2];
   end

   // bring the largest magnitude below 2^16
   always_comb begin
      logic [5:0]  msb;
      logic [5:0]  k;
      logic [33:0] sh;
      msb = 6'd0;
      for (int b = 0; b < 34; b++) begin
         if (sa_ff.mx[b]) msb = 6'(b);
      end
      k = (msb > 6'd15) ? (msb - 6'd15) : 6'd0;
      sb_in.vld  = sa_ff.vld;
      sb_in.neg  = sa_ff.neg;
      sb_in.side = sa_ff.side;
      for (int i = 0; i < 3; i++) begin
         sh = sa_ff.mag[i] >> k;
         sb_in.mag[i] = sh[15:0];
      end
   end

   always_comb begin
      sc_in.vld  = sb_ff.vld;
      sc_in.neg  = sb_ff.neg;
      sc_in.mag  = sb_ff.mag;
      sc_in.side = sb_ff.side;
      for (int i = 0; i < 3; i++) begin
         sc_in.sqr[i] = sb_ff.mag[i] * sb_ff.mag[i];
      end
   end

   always_comb begin
      logic [33:0] len;
      len = 34'(sc_ff.sqr[0]) + 34'(sc_ff.sqr[1]) + 34'(sc_ff.sqr[2]);
      sq_in[0].vld  = sc_ff.vld;
      sq_in[0].neg  = sc_ff.neg;
      sq_in[0].zero = (len == 34'd0);
      sq_in[0].mag  = sc_ff.mag;
      sq_in[0].x    = {len, 30'd0};
      sq_in[0].rem  = 35'd0;
      sq_in[0].root = 32'd0;
      sq_in[0].side = sc_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.vld <= 1'b0;
         sb_ff.vld <= 1'b0;
         sc_ff.vld <= 1'b0;
      end else if (en) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
         sc_ff <= sc_in;
      end
   end

   // square root, two radicand bits per stage
   genvar j;
   generate
      for (j = 0; j <= SQ_STEPS; j++) begin : g_sq
         if (j > 0) begin : g_step
            always_comb begin
               logic [34:0] rt;
               logic [34:0] trial;
               sq_in[j] = sq_ff[j-1];
               rt    = {sq_ff[j-1].rem[32:0], sq_ff[j-1].x[63:62]};
               trial = {1'b0, sq_ff[j-1].root, 2'b01};
               sq_in[j].x = {sq_ff[j-1].x[61:0], 2'b00};
               if (rt >= trial) begin
                  sq_in[j].rem  = rt - trial;
                  sq_in[j].root = {sq_ff[j-1].root[30:0], 1'b1};
               end else begin
                  sq_in[j].rem  = rt;
                  sq_in[j].root = {sq_ff[j-1].root[30:0], 1'b0};
               end
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               sq_ff[j].vld <= 1'b0;
            end else if (en) begin
               sq_ff[j] <= sq_in[j];
            end
         end
      end
   endgenerate

   // divider setup: q = (2*num + n) / (2*n)
   always_comb begin
      logic [47:0] dvd;
      dv_in[0].vld  = sq_ff[SQ_STEPS].vld;
      dv_in[0].neg  = sq_ff[SQ_STEPS].neg;
      dv_in[0].zero = sq_ff[SQ_STEPS].zero;
      dv_in[0].side = sq_ff[SQ_STEPS].side;
      dv_in[0].d    = {sq_ff[SQ_STEPS].root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         dvd = (48'(sq_ff[SQ_STEPS].mag[i]) << (FRAC + 16)) + 48'(sq_ff[SQ_STEPS].root);
         dv_in[0].r[i]   = 35'(dvd[47:17]);
         dv_in[0].dd[i]  = dvd[16:0];
         dv_in[0].q[i]   = 17'd0;
         dv_in[0].ovf[i] = (35'(dvd[47:17]) >= 35'(dv_in[0].d));
      end
   end

   generate
      for (j = 0; j <= DIV_STEPS; j++) begin : g_dv
         if (j > 0) begin : g_step
            always_comb begin
               logic [34:0] rt;
               dv_in[j] = dv_ff[j-1];
               for (int i = 0; i < 3; i++) begin
                  rt = {dv_ff[j-1].r[i][33:0], dv_ff[j-1].dd[i][16]};
                  dv_in[j].dd[i] = {dv_ff[j-1].dd[i][15:0], 1'b0};
                  if (rt >= 35'(dv_ff[j-1].d)) begin
                     dv_in[j].r[i] = rt - 35'(dv_ff[j-1].d);
                     dv_in[j].q[i] = {dv_ff[j-1].q[i][15:0], 1'b1};
                  end else begin
                     dv_in[j].r[i] = rt;
                     dv_in[j].q[i] = {dv_ff[j-1].q[i][15:0], 1'b0};
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[j].vld <= 1'b0;
            end else if (en) begin
               dv_ff[j] <= dv_in[j];
            end
         end
      end
   endgenerate

   // sign and saturation; zero length gives zero
   always_comb begin
      logic [16:0] q;
      logic        big;
      so_in.vld  = dv_ff[DIV_STEPS].vld;
      so_in.side = dv_ff[DIV_STEPS].side;
      for (int i = 0; i < 3; i++) begin
         q   = dv_ff[DIV_STEPS].q[i];
         big = 1'b0;
         if (dv_ff[DIV_STEPS].zero) begin
            so_in.v[i] = 16'sd0;
         end else if (dv_ff[DIV_STEPS].neg[i]) begin
            big = dv_ff[DIV_STEPS].ovf[i] || (q >= 17'd32768);
            so_in.v[i] = big ? 16'sh8000 : 16'((17'd0 - q));
         end else begin
            big = dv_ff[DIV_STEPS].ovf[i] || (q >= 17'd32767);
            so_in.v[i] = big ? 16'sh7fff : 16'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         so_ff.vld <= 1'b0;
      end else if (en) begin
         so_ff <= so_in;
      end
   end

   assign out_valid = so_ff.vld;
   assign out_v     = so_ff.v;
   assign out_side  = so_ff.side;

endmodule

[rtl/core/view_matrix_lookat.sv]
// Structure: two 55-stage normalizers, one cross-product stage and four stages for u
// and the translations lie between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Normalizer depth is set by the 32-step square root and the 17-step divider.
// Reset (synchronous, active high) empties the pipeline and sets up to (0, 16384, 0).
module view_matrix_lookat #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vml_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vml_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [15:0]      csr_wdata
);

   localparam logic [3:0] SH = 4'(DIR_FRAC_BITS);

   logic signed [15:0] up_x_ff, up_y_ff, up_z_ff;
   logic               en;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= 16'sd0;
         up_y_ff <= 16'sd16384;
         up_z_ff <= 16'sd0;
      end else if (csr_we) begin
         case (csr_addr)
            vml_pkg::CSR_UP_X: up_x_ff <= csr_wdata;
            vml_pkg::CSR_UP_Y: up_y_ff <= csr_wdata;
            vml_pkg::CSR_UP_Z: up_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // f = normalize(front)
   logic signed [2:0][33:0] n1_c;
   logic                    n1_vld;
   logic signed [2:0][15:0] n1_f;
   logic [95:0]             n1_side;

   assign n1_c[0] = 34'(req_data.front_x);
   assign n1_c[1] = 34'(req_data.front_y);
   assign n1_c[2] = 34'(req_data.front_z);

   // element 0 of the position vector is x
   vml_norm #(.FRAC(DIR_FRAC_BITS), .SW(96)) u_norm_f (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_c      (n1_c),
      .in_side   ({req_data.pos_z, req_data.pos_y, req_data.pos_x}),
      .out_valid (n1_vld),
      .out_v     (n1_f),
      .out_side  (n1_side)
   );

   // up x f
   logic                    x_vld_ff;
   logic signed [2:0][33:0] x_cr_ff;
   logic signed [2:0][15:0] x_f_ff;
   logic [95:0]             x_pos_ff;
   logic signed [2:0][33:0] x_cr_in;

   // elements of a packed array read as unsigned
   always_comb begin
      x_cr_in[0] = 34'(up_y_ff * $signed(n1_f[2])) - 34'(up_z_ff * $signed(n1_f[1]));
      x_cr_in[1] = 34'(up_z_ff * $signed(n1_f[0])) - 34'(up_x_ff * $signed(n1_f[2]));
      x_cr_in[2] = 34'(up_x_ff * $signed(n1_f[1])) - 34'(up_y_ff * $signed(n1_f[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
      end else if (en) begin
         x_vld_ff <= n1_vld;
         x_cr_ff  <= x_cr_in;
         x_f_ff   <= n1_f;
         x_pos_ff <= n1_side;
      end
   end

   // s = normalize(up x f)
   logic                    n2_vld;
   logic signed [2:0][15:0] n2_s;
   logic [143:0]            n2_side;

   vml_norm #(.FRAC(DIR_FRAC_BITS), .SW(144)) u_norm_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_vld_ff),
      .in_c      (x_cr_ff),
      .in_side   ({x_f_ff, x_pos_ff}),
      .out_valid (n2_vld),
      .out_v     (n2_s),
      .out_side  (n2_side)
   );

   logic signed [2:0][15:0] s2_f;
   logic signed [2:0][31:0] s2_p;

   assign s2_f = n2_side[143:96];
   assign s2_p = n2_side[95:0];

   // stage P: products
   logic                    p_vld_ff;
   logic signed [2:0][15:0] p_s_ff, p_f_ff;
   logic signed [2:0][31:0] p_p_ff;
   logic signed [5:0][31:0] p_fs_ff;
   logic signed [2:0][47:0] p_sp_ff, p_fp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff   <= n2_vld;
         p_s_ff     <= n2_s;
         p_f_ff     <= s2_f;
         p_p_ff     <= s2_p;
         p_fs_ff[0] <= $signed(s2_f[1]) * $signed(n2_s[2]);
         p_fs_ff[1] <= $signed(s2_f[2]) * $signed(n2_s[1]);
         p_fs_ff[2] <= $signed(s2_f[2]) * $signed(n2_s[0]);
         p_fs_ff[3] <= $signed(s2_f[0]) * $signed(n2_s[2]);
         p_fs_ff[4] <= $signed(s2_f[0]) * $signed(n2_s[1]);
         p_fs_ff[5] <= $signed(s2_f[1]) * $signed(n2_s[0]);
         for (int i = 0; i < 3; i++) begin
            p_sp_ff[i] <= 48'($signed(n2_s[i])) * 48'($signed(s2_p[i]));
            p_fp_ff[i] <= 48'($signed(s2_f[i])) * 48'($signed(s2_p[i]));
         end
      end
   end

   // stage Q: u, and translations of s and f
   logic                    q_vld_ff;
   logic signed [2:0][15:0] q_s_ff, q_f_ff, q_u_ff;
   logic signed [2:0][31:0] q_p_ff;
   logic signed [31:0]      q_st_ff, q_ft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff  <= p_vld_ff;
         q_s_ff    <= p_s_ff;
         q_f_ff    <= p_f_ff;
         q_p_ff    <= p_p_ff;
         q_u_ff[0] <= vml_pkg::rnd_sat16(34'($signed(p_fs_ff[0]))
                                         - 34'($signed(p_fs_ff[1])), SH);
         q_u_ff[1] <= vml_pkg::rnd_sat16(34'($signed(p_fs_ff[2]))
                                         - 34'($signed(p_fs_ff[3])), SH);
         q_u_ff[2] <= vml_pkg::rnd_sat16(34'($signed(p_fs_ff[4]))
                                         - 34'($signed(p_fs_ff[5])), SH);
         q_st_ff   <= vml_pkg::rnd_sat32(51'sd0 - 51'($signed(p_sp_ff[0]))
                                         - 51'($signed(p_sp_ff[1]))
                                         - 51'($signed(p_sp_ff[2])), SH);
         q_ft_ff   <= vml_pkg::rnd_sat32(51'sd0 - 51'($signed(p_fp_ff[0]))
                                         - 51'($signed(p_fp_ff[1]))
                                         - 51'($signed(p_fp_ff[2])), SH);
      end
   end

   // stage R: u products
   logic                    r_vld_ff;
   logic signed [2:0][15:0] r_s_ff, r_f_ff, r_u_ff;
   logic signed [31:0]      r_st_ff, r_ft_ff;
   logic signed [2:0][47:0] r_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (en) begin
         r_vld_ff <= q_vld_ff;
         r_s_ff   <= q_s_ff;
         r_f_ff   <= q_f_ff;
         r_u_ff   <= q_u_ff;
         r_st_ff  <= q_st_ff;
         r_ft_ff  <= q_ft_ff;
         for (int i = 0; i < 3; i++) begin
            r_up_ff[i] <= 48'($signed(q_u_ff[i])) * 48'($signed(q_p_ff[i]));
         end
      end
   end

   // output register
   logic             o_vld_ff;
   vml_pkg::rsp_type o_data_ff, o_data_in;

   always_comb begin
      o_data_in.right_x     = r_s_ff[0];
      o_data_in.right_y     = r_s_ff[1];
      o_data_in.right_z     = r_s_ff[2];
      o_data_in.right_shift = r_st_ff;
      o_data_in.upvec_x     = r_u_ff[0];
      o_data_in.upvec_y     = r_u_ff[1];
      o_data_in.upvec_z     = r_u_ff[2];
      o_data_in.upvec_shift = vml_pkg::rnd_sat32(51'sd0 - 51'($signed(r_up_ff[0]))
                                                 - 51'($signed(r_up_ff[1]))
                                                 - 51'($signed(r_up_ff[2])), SH);
      o_data_in.fwd_x       = r_f_ff[0];
      o_data_in.fwd_y       = r_f_ff[1];
      o_data_in.fwd_z       = r_f_ff[2];
      o_data_in.fwd_shift   = r_ft_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff  <= r_vld_ff;
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_data  = o_data_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int FRAC = 14;
   localparam int PIPE_DEPTH = 115;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      vml_pkg::req_type cam;
      bit typed;
      vml_pkg::rsp_type rows;
   } cam_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vml_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vml_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_addr = vml_pkg::CSR_UP_X;
   logic [15:0] csr_wdata = '0;

   vml_pkg::rsp_type pending_rows[$];
   cam_case_type cases[$];
   longint world_up[3];
   int send_idle_pct;
   int recv_stall_pct;
   int errors;
   int cycles;

   view_matrix_lookat dut (.*);

   always #10 clock = ~clock;

   // integer square root, floor
   function automatic longint unsigned isqrt(input longint unsigned x);
      longint unsigned r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x -= r + bit_v;
            r = (r >> 1) + bit_v;
         end else begin
            r >>= 1;
         end
         bit_v >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(input longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_shift(input longint v);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (FRAC - 1))) >> FRAC;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic void unit_vec(input longint c[3], output longint o[3]);
      longint unsigned m[3], mx, len2, n, num, q;
      int k;
      mx = 0;
      len2 = 0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      while ((mx >> k) >= (64'd1 << 16)) k++;
      for (int i = 0; i < 3; i++) begin
         m[i] >>= k;
         len2 += m[i] * m[i];
      end
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (len2 == 0) return;
      n = isqrt(len2 << 30);
      for (int i = 0; i < 3; i++) begin
         num = m[i] << (FRAC + 15);
         q = (2 * num + n) / (2 * n);
         o[i] = clamp(c[i] < 0 ? -longint'(q) : longint'(q), -32768, 32767);
      end
   endfunction

   function automatic longint shift_of(input longint a[3], input longint p[3]);
      longint d;
      d = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
      return clamp(round_shift(-d), -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic vml_pkg::rsp_type camera_rows(input vml_pkg::req_type c);
      longint fr[3], p[3], f[3], cr[3], s[3], u[3];
      vml_pkg::rsp_type r;
      fr = '{c.front_x, c.front_y, c.front_z};
      p = '{c.pos_x, c.pos_y, c.pos_z};
      unit_vec(fr, f);
      cr[0] = world_up[1] * f[2] - world_up[2] * f[1];
      cr[1] = world_up[2] * f[0] - world_up[0] * f[2];
      cr[2] = world_up[0] * f[1] - world_up[1] * f[0];
      unit_vec(cr, s);
      u[0] = clamp(round_shift(f[1] * s[2] - f[2] * s[1]), -32768, 32767);
      u[1] = clamp(round_shift(f[2] * s[0] - f[0] * s[2]), -32768, 32767);
      u[2] = clamp(round_shift(f[0] * s[1] - f[1] * s[0]), -32768, 32767);
      r.right_x = 16'(s[0]);
      r.right_y = 16'(s[1]);
      r.right_z = 16'(s[2]);
      r.right_shift = 32'(shift_of(s, p));
      r.upvec_x = 16'(u[0]);
      r.upvec_y = 16'(u[1]);
      r.upvec_z = 16'(u[2]);
      r.upvec_shift = 32'(shift_of(u, p));
      r.fwd_x = 16'(f[0]);
      r.fwd_y = 16'(f[1]);
      r.fwd_z = 16'(f[2]);
      r.fwd_shift = 32'(shift_of(f, p));
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report(field, got, want);
   endtask

   task automatic queue_rows(input vml_pkg::rsp_type rows);
      pending_rows.insert(pending_rows.size(), rows);
   endtask

   task automatic add_case(input cam_case_type cc);
      cases.insert(cases.size(), cc);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("status: fail");
         $finish;
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rows.size() == 0) begin
            report("unexpected item", 32'(rsp_data.fwd_shift), '0);
         end else begin
            vml_pkg::rsp_type e;
            e = pending_rows.pop_front();
            check_field("right_x", 32'(rsp_data.right_x), 32'(e.right_x));
            check_field("right_y", 32'(rsp_data.right_y), 32'(e.right_y));
            check_field("right_z", 32'(rsp_data.right_z), 32'(e.right_z));
            check_field("right_shift", rsp_data.right_shift, e.right_shift);
            check_field("upvec_x", 32'(rsp_data.upvec_x), 32'(e.upvec_x));
            check_field("upvec_y", 32'(rsp_data.upvec_y), 32'(e.upvec_y));
            check_field("upvec_z", 32'(rsp_data.upvec_z), 32'(e.upvec_z));
            check_field("upvec_shift", rsp_data.upvec_shift, e.upvec_shift);
            check_field("fwd_x", 32'(rsp_data.fwd_x), 32'(e.fwd_x));
            check_field("fwd_y", 32'(rsp_data.fwd_y), 32'(e.fwd_y));
            check_field("fwd_z", 32'(rsp_data.fwd_z), 32'(e.fwd_z));
            check_field("fwd_shift", rsp_data.fwd_shift, e.fwd_shift);
         end
      end
   end

   task automatic send(input vml_pkg::req_type c, input bit typed,
                       input vml_pkg::rsp_type rows);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (req_stall);
      queue_rows(typed ? rows : camera_rows(c));
   endtask

   // pipeline empty, then let any tail settle before touching the registers
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx != CSR_UNUSED) world_up[idx] = longint'(signed'(val));
   endtask

   task automatic set_up(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      csr_write(vml_pkg::CSR_UP_X, x);
      csr_write(vml_pkg::CSR_UP_Y, y);
      csr_write(vml_pkg::CSR_UP_Z, z);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(5))
         0: return 16'($urandom_range(511)) - 16'd256;
         1: return 16'd0;
         2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(4))
         0: return 32'($urandom_range(2000000)) - 32'd1000000;
         1: return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      vml_pkg::rsp_type r;
      vml_pkg::req_type c;
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      world_up = '{0, 16384, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // looking down +z, up +y: identity rotation
      r = '{right_x: 16384, right_y: 0, right_z: 0, right_shift: 0,
            upvec_x: 0, upvec_y: 16384, upvec_z: 0, upvec_shift: 0,
            fwd_x: 0, fwd_y: 0, fwd_z: 16384, fwd_shift: 0};
      add_case('{'{0, 0, 16384, 0, 0, 0}, 1, r});
      r.right_shift = -32'sd65536;
      add_case('{'{0, 0, 16384, 32'h10000, 0, 0}, 1, r});
      // zero-length front: everything zero
      add_case('{'{0, 0, 0, 32'h10000, 5, -7}, 1, '0});
      // front parallel to up: right and up axes collapse
      add_case('{'{0, 16384, 0, 0, 0, 0}, 1, '{fwd_y: 16384, default: 0}});
      add_case('{'{0, -16384, 0, 123, 456, 789}, 0, '0});
      add_case('{'{-32768, -32768, -32768, 32'h80000000, 32'h80000000,
                   32'h80000000}, 0, '0});
      add_case('{'{32767, 32767, 32767, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff}, 0, '0});
      add_case('{'{-32768, 0, 0, 32'h80000000, 32'h7fffffff, 0}, 0, '0});
      add_case('{'{0, 0, -32768, 32'h80000000, 0, 32'h80000000}, 0, '0});
      add_case('{'{1, 0, 0, 1, 1, 1}, 0, '0});
      add_case('{'{0, 0, -1, -1, -1, -1}, 0, '0});
      add_case('{'{1, 1, 1, 32'h7fffffff, 32'h80000000, 1}, 0, '0});
      add_case('{'{16384, 0, 16384, 32'h12345678, 32'hfedcba98, 0}, 0, '0});
      foreach (cases[i]) send(cases[i].cam, cases[i].typed, cases[i].rows);
      drain();

      // write to the unused index must leave up alone
      csr_write(CSR_UNUSED, 16'h1234);
      csr_we <= 1'b0;
      @(posedge clock);
      send('{0, 0, 16384, 0, 0, 0}, 0, '0);
      drain();

      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: set_up(16'h8000, 16'h8000, 16'h8000);
            1: set_up(16'h7fff, 16'h7fff, 16'h7fff);
            2: set_up(16'h0000, 16'h0000, 16'h0000);
            3: set_up(16'h7fff, 16'h8000, 16'h0001);
            4: set_up(16'h0000, 16'h4000, 16'h0000);
            default: set_up(rand_dir(), rand_dir(), rand_dir());
         endcase
         if (phase < 4) begin
            send_idle_pct = 6;
            recv_stall_pct = 84;
         end else if (phase < 8) begin
            send_idle_pct = 84;
            recv_stall_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         for (int n = 0; n < 100; n++) begin
            c.front_x = rand_dir();
            c.front_y = rand_dir();
            c.front_z = rand_dir();
            c.pos_x = rand_pos();
            c.pos_y = rand_pos();
            c.pos_z = rand_pos();
            send(c, 0, '0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
